[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/rld_pkg.sv]
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, constants and helpers of the LED strip driver.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam int PIXEL_COUNT  = 64;
    localparam int ADDR_W       = $clog2(PIXEL_COUNT);
    localparam int MIRROR_COUNT = (PIXEL_COUNT - 1) / 2;
    localparam int PIX_W        = 6;
    localparam int BIT_W        = 5;
    localparam int LAST_BIT     = 23;
    localparam int REG_IDX_W    = 1;

    localparam logic [ADDR_W-1:0]    LAST_ADDR      = ADDR_W'(PIXEL_COUNT - 1);
    localparam logic [REG_IDX_W-1:0] REG_SHORT_HIGH = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_LONG_EXTRA = REG_IDX_W'(1);

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SET    = 3'd1,
        OP_SCALE  = 3'd2,
        OP_BLEND  = 3'd3,
        OP_GET    = 3'd4,
        OP_MIRROR = 3'd5,
        OP_START  = 3'd6
    } op_t;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        pixel_t            data;
    } store_wr_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic              load;
        logic              blend;
        pixel_t            color_a;
        logic [7:0]        level;
        pixel_t            color_b;
        logic signed [9:0] prop;
    } color_req_t;

    // Map the pixel field onto a store address.
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [PIX_W-1:0] px);
        logic [31:0] wide;
        wide = 32'(px);
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic pix_in_range(input logic [PIX_W-1:0] px);
        return 32'(px) < 32'(PIXEL_COUNT);
    endfunction

endpackage

[rtl/rld_pixel_store.sv]
// ----------------------------------------------------------------------------
// rld_pixel_store
// Pixel memory, one G/R/B word per pixel, registered read, zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
module rld_pixel_store
    import rld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output pixel_t    rd_data,
    output logic      clearing
);

    pixel_t            mem [PIXEL_COUNT];
    pixel_t            rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

[rtl/rld_color_unit.sv]
// ----------------------------------------------------------------------------
// rld_color_unit
// Scaled and blended color: products registered, then divide-by-255 or
// Q8 sum formed combinationally from the registered products.
// ----------------------------------------------------------------------------
module rld_color_unit
    import rld_pkg::*;
(
    input  logic       clk,
    input  color_req_t req,
    output pixel_t     color
);

    logic [7:0]  c_a [3];
    logic [7:0]  c_b [3];
    logic [8:0]  w_a;
    logic [8:0]  w_b;
    logic [8:0]  mul_lhs;
    logic [16:0] prod_a_next [3];
    logic [16:0] prod_b_next [3];
    logic [16:0] prod_a_reg [3];
    logic [16:0] prod_b_reg [3];
    logic        blend_reg;
    logic [16:0] sum [3];

    assign c_a[0] = req.color_a.green;
    assign c_a[1] = req.color_a.red;
    assign c_a[2] = req.color_a.blue;
    assign c_b[0] = req.color_b.green;
    assign c_b[1] = req.color_b.red;
    assign c_b[2] = req.color_b.blue;

    // Clamp the proportion: above one keeps the first color, below zero the second.
    always_comb
    begin
        if (req.prop > 10'sd256)
        begin
            w_a = 9'd256;
        end
        else if (req.prop[9])
        begin
            w_a = 9'd0;
        end
        else
        begin
            w_a = req.prop[8:0];
        end
        w_b     = 9'd256 - w_a;
        mul_lhs = req.blend ? w_a : {1'b0, req.level};
        for (int i = 0; i < 3; i++)
        begin
            prod_a_next[i] = 17'(mul_lhs) * 17'(c_a[i]);
            prod_b_next[i] = req.blend ? 17'(w_b) * 17'(c_b[i]) : 17'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            blend_reg <= req.blend;
            for (int i = 0; i < 3; i++)
            begin
                prod_a_reg[i] <= prod_a_next[i];
                prod_b_reg[i] <= prod_b_next[i];
            end
        end
    end

    // floor(x/255) = (x + (x >> 8) + 1) >> 8 for every x below 65535.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (blend_reg)
            begin
                sum[i] = prod_a_reg[i] + prod_b_reg[i];
            end
            else
            begin
                sum[i] = prod_a_reg[i] + {8'd0, prod_a_reg[i][16:8]} + 17'd1;
            end
        end
    end

    assign color.green = sum[0][15:8];
    assign color.red   = sum[1][15:8];
    assign color.blue  = sum[2][15:8];

endmodule

[rtl/rgb_led_strip_driver.sv]
// ----------------------------------------------------------------------------
// rgb_led_strip_driver
// Set, start, idle tick and the unused code go from idle straight to done;
// a sending tick, get, scaled set and blend first pass one working state;
// mirror loops in its write state. One word at a time: the sequencer owns
// the single pixel memory port pair, so a new word is taken only back in idle.
// Reset: sending stops, registers reload to 2 and 7, and a zeroing sweep
// over the whole store runs while input is stalled.
// ----------------------------------------------------------------------------
module rgb_led_strip_driver
    import rld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 write_enable,
    input  logic [REG_IDX_W-1:0] write_index,
    input  logic [7:0]           write_data,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           operation,
    input  logic [PIX_W-1:0]     pixel,
    input  logic [7:0]           green,
    input  logic [7:0]           red,
    input  logic [7:0]           blue,
    input  logic [7:0]           green_b,
    input  logic [7:0]           red_b,
    input  logic [7:0]           blue_b,
    input  logic [7:0]           level,
    input  logic signed [9:0]    proportion,
    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           read_green,
    output logic [7:0]           read_red,
    output logic [7:0]           read_blue,
    output logic                 pulse_valid,
    output logic                 pulse_bit,
    output logic [8:0]           pulse_high_time,
    output logic                 frame_done,
    output logic                 busy_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_GET,
        S_COLOR,
        S_MIR_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        pixel_t     rd;
        logic       pulse_valid;
        logic       pulse_bit;
        logic [8:0] high_time;
        logic       frame_done;
        logic       busy;
    } result_t;

    // Sequencer and frame state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] px_reg, px_next;
    logic              in_range_reg, in_range_next;
    logic [ADDR_W-1:0] mir_reg, mir_next;
    logic              sending_reg, sending_next;
    logic [ADDR_W-1:0] tx_pixel_reg, tx_pixel_next;
    logic [BIT_W-1:0]  tx_bit_reg, tx_bit_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // Configuration registers
    logic [7:0]        short_reg;
    logic [7:0]        long_reg;

    // Memory and arithmetic hookup
    store_wr_t         st_wr;
    store_rd_t         st_rd;
    pixel_t            st_rd_data;
    logic              clearing;
    color_req_t        col_req;
    pixel_t            col_out;

    logic              accept;
    logic              out_free;
    op_t               op;
    logic [BIT_W-1:0]  bit_idx;
    logic              tx_bit_val;
    logic [ADDR_W-1:0] mir_inc;

    rld_pixel_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (st_wr),
        .rd       (st_rd),
        .rd_data  (st_rd_data),
        .clearing (clearing)
    );

    rld_color_unit u_color (
        .clk   (clk),
        .req   (col_req),
        .color (col_out)
    );

    // Input is taken only in idle and never during the zeroing sweep.
    assign in_stall = clearing || (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign op       = op_t'(operation);
    assign mir_inc  = mir_reg + 1'b1;

    // Bits go MSB first over the packed G,R,B word.
    assign bit_idx    = BIT_W'(LAST_BIT) - tx_bit_reg;
    assign tx_bit_val = st_rd_data[bit_idx];

    // Load products on every accepted word; only scale and blend use them.
    always_comb
    begin
        col_req.load    = accept;
        col_req.blend   = (op == OP_BLEND);
        col_req.color_a = '{green: green, red: red, blue: blue};
        col_req.color_b = '{green: green_b, red: red_b, blue: blue_b};
        col_req.level   = level;
        col_req.prop    = proportion;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= 8'd2;
            long_reg  <= 8'd7;
        end
        else if (write_enable)
        begin
            if (write_index == REG_SHORT_HIGH)
            begin
                short_reg <= write_data;
            end
            else if (write_index == REG_LONG_EXTRA)
            begin
                long_reg <= write_data;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        in_range_next  = in_range_reg;
        mir_next       = mir_reg;
        sending_next   = sending_reg;
        tx_pixel_next  = tx_pixel_reg;
        tx_bit_next    = tx_bit_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        st_wr          = '0;
        st_rd          = '0;

        // Drop the result once the far side takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    px_next       = pix_addr(pixel);
                    in_range_next = pix_in_range(pixel);
                    res_next      = '0;
                    res_next.busy = sending_reg;
                    state_next    = S_DONE;
                    case (op)
                        OP_TICK:
                        begin
                            if (sending_reg)
                            begin
                                st_rd.re   = 1'b1;
                                st_rd.addr = tx_pixel_reg;
                                state_next = S_TICK;
                            end
                        end
                        OP_SET:
                        begin
                            st_wr.we   = pix_in_range(pixel);
                            st_wr.addr = pix_addr(pixel);
                            st_wr.data = '{green: green, red: red, blue: blue};
                        end
                        OP_SCALE, OP_BLEND:
                        begin
                            state_next = S_COLOR;
                        end
                        OP_GET:
                        begin
                            st_rd.re   = 1'b1;
                            st_rd.addr = pix_addr(pixel);
                            state_next = S_GET;
                        end
                        OP_MIRROR:
                        begin
                            if (MIRROR_COUNT > 0)
                            begin
                                st_rd.re   = 1'b1;
                                st_rd.addr = '0;
                                mir_next   = '0;
                                state_next = S_MIR_WR;
                            end
                        end
                        OP_START:
                        begin
                            sending_next  = 1'b1;
                            res_next.busy = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                res_next.pulse_valid = 1'b1;
                res_next.pulse_bit   = tx_bit_val;
                res_next.high_time   = {1'b0, short_reg}
                                     + (tx_bit_val ? {1'b0, long_reg} : 9'd0);
                if (tx_bit_reg == BIT_W'(LAST_BIT))
                begin
                    tx_bit_next = '0;
                    if (tx_pixel_reg == LAST_ADDR)
                    begin
                        tx_pixel_next       = '0;
                        sending_next        = 1'b0;
                        res_next.frame_done = 1'b1;
                        res_next.busy       = 1'b0;
                    end
                    else
                    begin
                        tx_pixel_next = tx_pixel_reg + 1'b1;
                    end
                end
                else
                begin
                    tx_bit_next = tx_bit_reg + 1'b1;
                end
                state_next = S_DONE;
            end

            S_GET:
            begin
                if (in_range_reg)
                begin
                    res_next.rd = st_rd_data;
                end
                state_next = S_DONE;
            end

            S_COLOR:
            begin
                st_wr.we   = in_range_reg;
                st_wr.addr = px_reg;
                st_wr.data = col_out;
                state_next = S_DONE;
            end

            S_MIR_WR:
            begin
                // Write the mirrored pixel and, unless it was the last, fetch the next source in the same cycle.
                st_wr.we   = 1'b1;
                st_wr.addr = LAST_ADDR - mir_reg;
                st_wr.data = st_rd_data;
                if (mir_reg == ADDR_W'(MIRROR_COUNT - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    st_rd.re   = 1'b1;
                    st_rd.addr = mir_inc;
                    mir_next   = mir_inc;
                end
            end

            S_DONE:
            begin
                // Hold here while the output register still carries an untaken word.
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sending_reg   <= 1'b0;
            tx_pixel_reg  <= '0;
            tx_bit_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sending_reg   <= sending_next;
            tx_pixel_reg  <= tx_pixel_next;
            tx_bit_reg    <= tx_bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        in_range_reg <= in_range_next;
        mir_reg      <= mir_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign read_green      = out_reg.rd.green;
    assign read_red        = out_reg.rd.red;
    assign read_blue       = out_reg.rd.blue;
    assign pulse_valid     = out_reg.pulse_valid;
    assign pulse_bit       = out_reg.pulse_bit;
    assign pulse_high_time = out_reg.high_time;
    assign frame_done      = out_reg.frame_done;
    assign busy_res        = out_reg.busy;

endmodule

[rtl/rld_checker.sv]
// ----------------------------------------------------------------------------
// rld_checker
// Port-level checks on the result channel of the LED strip driver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rld_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_green,
    input logic [7:0] read_red,
    input logic [7:0] read_blue,
    input logic       pulse_valid,
    input logic       pulse_bit,
    input logic [8:0] pulse_high_time,
    input logic       frame_done,
    input logic       busy_res
);

    // No bit sent means all pulse fields stay clear.
    `CHK_SAME(a_idle_pulse, clk, rst_n, out_valid && !pulse_valid, !pulse_bit && pulse_high_time == 9'd0 && !frame_done)

    // The last bit of a frame drops the sending flag.
    `CHK_SAME(a_done_ends, clk, rst_n, out_valid && frame_done, pulse_valid && !busy_res)

    // A pulse word never carries read-back data.
    `CHK_SAME(a_pulse_no_read, clk, rst_n, out_valid && pulse_valid, read_green == 8'd0 && read_red == 8'd0 && read_blue == 8'd0)

    // A stalled result word holds.
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pulse_high_time) && $stable(busy_res) && $stable(read_green))

endmodule

bind rgb_led_strip_driver rld_checker u_rld_checker (.*);

[tb/rgb_led_strip_driver_test.sv]
// ----------------------------------------------------------------------------
// rgb_led_strip_driver_test
// Drives operation words into the LED strip driver and checks every result
// word against a cycle-free model of the pixel store and the bit serializer.
// A directed opener covers field extremes, every operation and the corner
// cases; random phases then sweep the two timing registers through their
// extremes, with random gaps and stalls in most phases.
// ----------------------------------------------------------------------------
module rgb_led_strip_driver_test
    import rld_pkg::*;
();

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int FRAME_BITS   = PIXEL_COUNT * 24;
    localparam int PHASES       = 6;
    localparam int WORDS_PER_PHASE = 140;
    // Mirror is the slowest word; size the drain wait from its mirror count.
    localparam int DRAIN_CYCLES = 2 * MIRROR_COUNT + 8;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int REPORT_MAX   = 10;

    // Operation code seven has no member in the package enum.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // One operation word as it goes onto the input channel.
    typedef struct packed {
        logic [2:0]        op;
        logic [PIX_W-1:0]  pixel;
        pixel_t            color_a;
        pixel_t            color_b;
        logic [7:0]        level;
        logic signed [9:0] prop;
    } strip_word_t;

    // One result word as it comes off the output channel.
    typedef struct packed {
        pixel_t     read_px;
        logic       sent;
        logic       sent_bit;
        logic [8:0] high_time;
        logic       last_bit;
        logic       busy;
    } strip_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's input ports, all known from time zero
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 write_enable = 1'b0;
    logic [REG_IDX_W-1:0] write_index  = '0;
    logic [7:0]           write_data   = '0;

    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [2:0]           operation  = '0;
    logic [PIX_W-1:0]     pixel      = '0;
    logic [7:0]           green      = '0;
    logic [7:0]           red        = '0;
    logic [7:0]           blue       = '0;
    logic [7:0]           green_b    = '0;
    logic [7:0]           red_b      = '0;
    logic [7:0]           blue_b     = '0;
    logic [7:0]           level      = '0;
    logic signed [9:0]    proportion = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           read_green;
    logic [7:0]           read_red;
    logic [7:0]           read_blue;
    logic                 pulse_valid;
    logic                 pulse_bit;
    logic [8:0]           pulse_high_time;
    logic                 frame_done;
    logic                 busy_res;

    always #(HALF_PERIOD) clk = ~clk;

    rgb_led_strip_driver dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .write_enable    (write_enable),
        .write_index     (write_index),
        .write_data      (write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .pixel           (pixel),
        .green           (green),
        .red             (red),
        .blue            (blue),
        .green_b         (green_b),
        .red_b           (red_b),
        .blue_b          (blue_b),
        .level           (level),
        .proportion      (proportion),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_green      (read_green),
        .read_red        (read_red),
        .read_blue       (read_blue),
        .pulse_valid     (pulse_valid),
        .pulse_bit       (pulse_bit),
        .pulse_high_time (pulse_high_time),
        .frame_done      (frame_done),
        .busy_res        (busy_res)
    );

    // ------------------------------------------------------------------
    // Strip model: its own copy of the store, serializer and registers
    // ------------------------------------------------------------------
    pixel_t      strip_mem [PIXEL_COUNT] = '{default: '0};
    logic [10:0] frame_pos    = '0;
    logic        frame_active = 1'b0;
    logic [7:0]  short_cfg    = 8'd2;   // register reset values
    logic [7:0]  long_cfg     = 8'd7;

    strip_word_t   word_queue [$];      // words waiting for the driver
    strip_result_t strip_expected [$];  // predicted results, oldest first

    strip_word_t cur_word   = '0;       // word currently on the input port
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    bit          gaps_on    = 1'b1;
    bit          stall_on   = 1'b1;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] lvl);
        return 8'((int'(c) * int'(lvl)) / 255);
    endfunction

    // Q8 mix; only called with the share already inside 0..256.
    function automatic logic [7:0] mix8(input logic [7:0] c1, input logic [7:0] c2,
                                        input int p);
        return 8'((p * int'(c1) + (256 - p) * int'(c2)) >> 8);
    endfunction

    function automatic void store_pixel(input logic [PIX_W-1:0] px, input pixel_t c);
        if (int'(px) < PIXEL_COUNT)
            strip_mem[px] = c;
    endfunction

    // Advance the model by one accepted word and return its result.
    function automatic strip_result_t strip_step(input strip_word_t w);
        strip_result_t r;
        logic [23:0]   pix_bits;
        logic          bit_now;
        int            p;
        r = '0;
        p = $signed(w.prop);
        case (w.op)
            OP_TICK:
                if (frame_active)
                begin
                    // MSB first, green then red then blue within a pixel
                    pix_bits    = strip_mem[frame_pos / 24];
                    bit_now     = pix_bits[23 - (frame_pos % 24)];
                    r.sent      = 1'b1;
                    r.sent_bit  = bit_now;
                    r.high_time = 9'(short_cfg) + (bit_now ? 9'(long_cfg) : 9'd0);
                    if (int'(frame_pos) == FRAME_BITS - 1)
                    begin
                        frame_pos    = '0;
                        frame_active = 1'b0;
                        r.last_bit   = 1'b1;
                    end
                    else
                        frame_pos = frame_pos + 1'b1;
                end
            OP_SET:
                store_pixel(w.pixel, w.color_a);
            OP_SCALE:
                store_pixel(w.pixel, '{green: scale8(w.color_a.green, w.level),
                                       red:   scale8(w.color_a.red,   w.level),
                                       blue:  scale8(w.color_a.blue,  w.level)});
            OP_BLEND:
                if (p > 256)
                    store_pixel(w.pixel, w.color_a);
                else if (p < 0)
                    store_pixel(w.pixel, w.color_b);
                else
                    store_pixel(w.pixel, '{green: mix8(w.color_a.green, w.color_b.green, p),
                                           red:   mix8(w.color_a.red,   w.color_b.red,   p),
                                           blue:  mix8(w.color_a.blue,  w.color_b.blue,  p)});
            OP_GET:
                if (int'(w.pixel) < PIXEL_COUNT)
                    r.read_px = strip_mem[w.pixel];
            OP_MIRROR:
                for (int i = 0; i < MIRROR_COUNT; i++)
                    strip_mem[PIXEL_COUNT - 1 - i] = strip_mem[i];
            OP_START:
                frame_active = 1'b1;
            default:
                ;
        endcase
        r.busy = frame_active;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic strip_word_t make_word(input logic [2:0] op, input int px,
                                              input int g, input int r, input int b,
                                              input int g2, input int r2, input int b2,
                                              input int lvl, input int prop);
        strip_word_t w;
        w.op      = op;
        w.pixel   = PIX_W'(px);
        w.color_a = '{green: 8'(g), red: 8'(r), blue: 8'(b)};
        w.color_b = '{green: 8'(g2), red: 8'(r2), blue: 8'(b2)};
        w.level   = 8'(lvl);
        w.prop    = 10'(prop);
        return w;
    endfunction

    function automatic strip_word_t random_word();
        strip_word_t w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      w.op = OP_TICK;
        else if (pick < 50) w.op = OP_SET;
        else if (pick < 60) w.op = OP_SCALE;
        else if (pick < 72) w.op = OP_BLEND;
        else if (pick < 86) w.op = OP_GET;
        else if (pick < 89) w.op = OP_MIRROR;
        else if (pick < 95) w.op = OP_START;
        else                w.op = OP_UNUSED;
        w.pixel   = PIX_W'($urandom_range(0, PIXEL_COUNT - 1));
        w.color_a = 24'($urandom);
        w.color_b = 24'($urandom);
        pick = $urandom_range(0, 9);
        w.level = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
        // Keep most shares inside the mixing range, the rest anywhere.
        w.prop = $urandom_range(0, 1) ? 10'($urandom_range(0, 256)) : 10'($urandom);
        return w;
    endfunction

    // Mostly zero, often short, now and then long.
    function automatic int unsigned draw_pause();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict each accepted word, then present the next one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : send_side
        strip_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                strip_expected.push_back(strip_step(cur_word));
            // Hold the payload while stalled; otherwise idle or advance.
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (word_queue.size() != 0)
                begin
                    w = word_queue.pop_front();
                    cur_word   <= w;
                    operation  <= w.op;
                    pixel      <= w.pixel;
                    green      <= w.color_a.green;
                    red        <= w.color_a.red;
                    blue       <= w.color_a.blue;
                    green_b    <= w.color_b.green;
                    red_b      <= w.color_b.red;
                    blue_b     <= w.color_b.blue;
                    level      <= w.level;
                    proportion <= w.prop;
                    in_valid   <= 1'b1;
                    gap_left   <= gaps_on ? draw_pause() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result, then draw the next stall
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : recv_side
        strip_result_t got;
        strip_result_t want;
        int unsigned   n;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.read_px   = '{green: read_green, red: read_red, blue: read_blue};
                got.sent      = pulse_valid;
                got.sent_bit  = pulse_bit;
                got.high_time = pulse_high_time;
                got.last_bit  = frame_done;
                got.busy      = busy_res;
                if (strip_expected.size() == 0)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("cycle %0d: result word with nothing expected", cycle_count);
                    mismatch_count++;
                end
                else
                begin
                    want = strip_expected.pop_front();
                    if (got.read_px !== want.read_px || got.sent !== want.sent ||
                        got.sent_bit !== want.sent_bit || got.high_time !== want.high_time ||
                        got.last_bit !== want.last_bit || got.busy !== want.busy)
                    begin
                        if (mismatch_count < REPORT_MAX)
                            $display({"cycle %0d: mismatch\n",
                                      "  expected grb=%h pulse=%b bit=%b high=%0d done=%b busy=%b\n",
                                      "  actual   grb=%h pulse=%b bit=%b high=%0d done=%b busy=%b"},
                                     cycle_count,
                                     want.read_px, want.sent, want.sent_bit, want.high_time,
                                     want.last_bit, want.busy,
                                     got.read_px, got.sent, got.sent_bit, got.high_time,
                                     got.last_bit, got.busy);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                n = stall_on ? draw_pause() : 0;
                out_stall  <= (n != 0);
                stall_left <= (n != 0) ? n - 1 : 0;
            end
        end
    end

    // Bound the run in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // Return once the sender is idle and every predicted word has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (word_queue.size() != 0 || strip_expected.size() != 0 || in_valid);
    endtask

    // Only call while drained, so no word sees a half-updated register.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= val;
        @(posedge clk);
        write_enable <= 1'b0;
        if (idx == REG_SHORT_HIGH)
            short_cfg = val;
        else
            long_cfg = val;
    endtask

    initial
    begin
        logic [7:0] short_val;
        logic [7:0] long_val;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opener: fresh store, idle tick, unused code, extremes,
        // every set flavor at its edges, mirror, and a restart mid-frame.
        word_queue.push_back(make_word(OP_GET,     0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_TICK,    0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_UNUSED, 63, 255, 255, 255, 255, 255, 255, 255,   -1));
        word_queue.push_back(make_word(OP_SET,    63, 255, 255, 255,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_GET,    63,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_SET,     0, 128,   1, 170,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_SCALE,   1, 255, 255, 255,   0,   0,   0, 255,    0));
        word_queue.push_back(make_word(OP_SCALE,   2, 255, 255, 255,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_SCALE,   3, 255,   1, 200,   0,   0,   0, 128,    0));
        word_queue.push_back(make_word(OP_BLEND,   4, 200, 100,  50,  10,  20,  30,   0,  256));
        word_queue.push_back(make_word(OP_BLEND,   5, 200, 100,  50,  10,  20,  30,   0,    0));
        word_queue.push_back(make_word(OP_BLEND,   6, 200, 100,  50,  10,  20,  30,   0,  257));
        word_queue.push_back(make_word(OP_BLEND,   7, 200, 100,  50,  10,  20,  30,   0,   -1));
        word_queue.push_back(make_word(OP_BLEND,   8, 255, 255, 255,   0,   0,   0,   0,  511));
        word_queue.push_back(make_word(OP_BLEND,   9, 255, 255, 255,   0,   0,   0,   0, -512));
        word_queue.push_back(make_word(OP_BLEND,  10, 255,   0, 255,   0, 255,   1,   0,  128));
        word_queue.push_back(make_word(OP_GET,    10,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_MIRROR,  0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_GET,    63,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_GET,    32,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_START,   0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_TICK,    0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_START,   0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_TICK,    0,   0,   0,   0,   0,   0,   0,   0,    0));
        word_queue.push_back(make_word(OP_SET,     0,  15, 240,  60,   0,   0,   0,   0,    0));
        wait_drained();

        // Random phases: each one runs under its own register setting and its
        // own mix of sender gaps and receiver stalls; phase 1 has neither.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1:       begin short_val = 8'd0;   long_val = 8'd0;   end
                2:       begin short_val = 8'd255; long_val = 8'd255; end
                3:       begin short_val = 8'd0;   long_val = 8'd255; end
                4:       begin short_val = 8'd255; long_val = 8'd0;   end
                default: begin short_val = 8'($urandom); long_val = 8'($urandom); end
            endcase
            if (ph > 0)
            begin
                write_reg(REG_SHORT_HIGH, short_val);
                write_reg(REG_LONG_EXTRA, long_val);
            end
            gaps_on  = (ph != 1 && ph != 2);
            stall_on = (ph != 1 && ph != 4);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
                word_queue.push_back(random_word());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && strip_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
